@@ rtl/core/atgr_pkg.sv @@
// Shared types, widths and constants of the tilt and gyro rate block.
// Depends on nothing; every other file of the block uses it.
package atgr_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AngleTableLen      = 24;
  localparam int unsigned SqW   = 32;  // a^2 + b^2
  localparam int unsigned RootW = 26;  // floor(sqrt(s * 2^20))
  localparam int unsigned RemW  = 28;
  localparam int unsigned XyW   = 30;
  localparam int unsigned ZW    = 33;
  localparam int unsigned BiasW = 24;
  localparam int unsigned ProdW = 51;
  localparam logic signed [24:0] RateMul = 25'sd9150552;
  localparam logic signed [16:0] TiltLimit = 17'sd25736;

  typedef enum logic [1:0] {
    REG_BIAS_X = 2'd0,
    REG_BIAS_Y = 2'd1,
    REG_BIAS_Z = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } res_t;

  // Angle table in Q2.30, entries truncated.
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] t [AngleTableLen];
    t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
          32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
          32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
          32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
          32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
          32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
    return t[idx];
  endfunction

endpackage

@@ rtl/core/atgr_sqrt_cell.sv @@
// One digit cell of the pipelined integer square root.
// Depends on atgr_pkg.
module atgr_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic vld_i,
  input  logic [atgr_pkg::SqW-1:0] s_i,
  input  logic [atgr_pkg::RootW-1:0] root_i,
  input  logic [atgr_pkg::RemW-1:0] rem_i,
  input  logic signed [15:0] num_i,
  input  logic zero_i,
  output logic vld_o,
  output logic [atgr_pkg::SqW-1:0] s_o,
  output logic [atgr_pkg::RootW-1:0] root_o,
  output logic [atgr_pkg::RemW-1:0] rem_o,
  output logic signed [15:0] num_o,
  output logic zero_o
);

  localparam int unsigned VW = 2 * atgr_pkg::RootW;

  logic [VW-1:0] v;
  logic [atgr_pkg::RemW-1:0] r2, trial;
  logic vld_q;
  logic [atgr_pkg::SqW-1:0] s_q;
  logic [atgr_pkg::RootW-1:0] root_q;
  logic [atgr_pkg::RemW-1:0] rem_q;
  logic signed [15:0] num_q;
  logic zero_q;

  // The radicand is s shifted up by twenty bits; each cell takes one bit pair.
  assign v     = {s_i, {(VW - atgr_pkg::SqW){1'b0}}};
  assign r2    = {rem_i[atgr_pkg::RemW-3:0], v[VW-1-2*K -: 2]};
  assign trial = {root_i[atgr_pkg::RemW-3:0], 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_i;
    num_q  <= num_i;
    zero_q <= zero_i;
    if (r2 >= trial) begin
      rem_q  <= r2 - trial;
      root_q <= {root_i[atgr_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_q  <= r2;
      root_q <= {root_i[atgr_pkg::RootW-2:0], 1'b0};
    end
  end

  assign vld_o  = vld_q;
  assign s_o    = s_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign zero_o = zero_q;

endmodule

@@ rtl/core/atgr_cordic_cell.sv @@
// One rotation cell of the vectoring CORDIC.
// Depends on atgr_pkg for widths and the angle table.
module atgr_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic vld_i,
  input  logic signed [atgr_pkg::XyW-1:0] x_i,
  input  logic signed [atgr_pkg::XyW-1:0] y_i,
  input  logic signed [atgr_pkg::ZW-1:0] z_i,
  input  logic zero_i,
  output logic vld_o,
  output logic signed [atgr_pkg::XyW-1:0] x_o,
  output logic signed [atgr_pkg::XyW-1:0] y_o,
  output logic signed [atgr_pkg::ZW-1:0] z_o,
  output logic zero_o
);

  logic signed [atgr_pkg::XyW-1:0] dx, dy;
  logic signed [atgr_pkg::ZW-1:0] ang;
  logic vld_q, zero_q;
  logic signed [atgr_pkg::XyW-1:0] x_q, y_q;
  logic signed [atgr_pkg::ZW-1:0] z_q;

  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;
  assign ang = $signed({1'b0, atgr_pkg::atan_q30(STEP)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_i;
    if (!y_i[atgr_pkg::XyW-1]) begin
      x_q <= x_i + dx;
      y_q <= y_i - dy;
      z_q <= z_i + ang;
    end else begin
      x_q <= x_i - dx;
      y_q <= y_i + dy;
      z_q <= z_i - ang;
    end
  end

  assign vld_o  = vld_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;

endmodule

@@ rtl/core/atgr_rate.sv @@
// Gyro rate path for one axis: bias removal, scaling, rounding, saturation.
// Two register stages. Depends on atgr_pkg.
module atgr_rate (
  input  logic clk_i,
  input  logic signed [15:0] rot_i,
  input  logic signed [atgr_pkg::BiasW-1:0] bias_i,
  output logic signed [15:0] rate_o
);

  logic signed [25:0] d;
  logic signed [atgr_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [atgr_pkg::ProdW-1:0] rnd;
  logic signed [18:0] t;
  logic signed [15:0] rate_d, rate_q;

  assign d      = {{2{rot_i[15]}}, rot_i, 8'b0} - {{2{bias_i[atgr_pkg::BiasW-1]}}, bias_i};
  assign prod_d = atgr_pkg::ProdW'(d * atgr_pkg::RateMul);
  assign rnd    = prod_q + (atgr_pkg::ProdW'(1) <<< 31);
  assign t      = rnd[50:32];

  always_comb begin
    if (t > 19'sd32767) begin
      rate_d = 16'sh7FFF;
    end else if (t < -19'sd32768) begin
      rate_d = -16'sh8000;
    end else begin
      rate_d = t[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rate_q <= rate_d;
  end

  assign rate_o = rate_q;

endmodule

@@ rtl/core/accel_tilt_and_gyro_rate.sv @@
// Top level of the tilt and gyro rate block.
// Depends on atgr_pkg, atgr_sqrt_cell, atgr_cordic_cell and atgr_rate.
//
// Usage: a six-axis sample word is accepted at each rising edge where
// start_i is high and busy_o is low. busy_o is always low, so a new word
// may be offered in every cycle and the block takes one word per cycle.
// Each accepted word yields exactly one result word on res_o, marked by
// done_o for a single cycle; the receiver cannot stall and must take it.
// The tilt path runs as follows: a front stage forms the sums of squares,
// a row of 26 square root cells delivers the hypot one bit per cell,
// a row of CORDIC_STEPS rotation cells resolves the angle, and one output
// register rounds and clamps. The gyro rates are computed by atgr_rate and
// delayed to line up with the tilt angles. The user must write the bias
// registers through cfg_we_i, cfg_idx_i and cfg_data_i only while no word
// is in flight; the block does not enforce it. An unknown index is ignored.
// Reset clears the biases and all valid flags; words in flight are lost.
module accel_tilt_and_gyro_rate #(
  parameter int unsigned CORDIC_STEPS = atgr_pkg::CordicStepsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  atgr_pkg::in_t in_i,
  output logic done_o,
  output atgr_pkg::res_t res_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [atgr_pkg::BiasW-1:0] cfg_data_i
);

  localparam int unsigned RW = atgr_pkg::RootW;
  localparam int unsigned DLY = RW - 1 + CORDIC_STEPS;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers.
  logic signed [atgr_pkg::BiasW-1:0] bias_x_q, bias_y_q, bias_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q <= '0;
      bias_y_q <= '0;
      bias_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (atgr_pkg::reg_idx_e'(cfg_idx_i))
        atgr_pkg::REG_BIAS_X: bias_x_q <= cfg_data_i;
        atgr_pkg::REG_BIAS_Y: bias_y_q <= cfg_data_i;
        atgr_pkg::REG_BIAS_Z: bias_z_q <= cfg_data_i;
        atgr_pkg::REG_NONE:   ;
        default: ;
      endcase
    end
  end

  // Front stage: sums of squares, numerators and the zero-vector flag.
  // Path 0 gives tilt_x (numerator ay), path 1 gives tilt_y (numerator ax).
  logic vld0_q;
  logic [atgr_pkg::SqW-1:0] sq_q [2];
  logic signed [15:0] num_q [2];
  logic zero_q [2];
  logic [atgr_pkg::SqW-1:0] sq_d [2];
  logic signed [31:0] p_xx, p_yy, p_zz;

  assign p_xx = in_i.acc_x * in_i.acc_x;
  assign p_yy = in_i.acc_y * in_i.acc_y;
  assign p_zz = in_i.acc_z * in_i.acc_z;
  assign sq_d[0] = $unsigned(p_xx) + $unsigned(p_zz);
  assign sq_d[1] = $unsigned(p_yy) + $unsigned(p_zz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0]   <= sq_d[0];
    sq_q[1]   <= sq_d[1];
    num_q[0]  <= in_i.acc_y;
    num_q[1]  <= in_i.acc_x;
    zero_q[0] <= (sq_d[0] == '0) && (in_i.acc_y == 16'sd0);
    zero_q[1] <= (sq_d[1] == '0) && (in_i.acc_x == 16'sd0);
  end

  // Both tilt paths: square root row followed by the CORDIC row.
  logic vld_t [2];
  logic signed [atgr_pkg::ZW-1:0] z_t [2];
  logic zero_t [2];

  for (genvar p = 0; p < 2; p++) begin : g_path
    logic vld_s [RW+1];
    logic [atgr_pkg::SqW-1:0] s_s [RW+1];
    logic [RW-1:0] root_s [RW+1];
    logic [atgr_pkg::RemW-1:0] rem_s [RW+1];
    logic signed [15:0] num_s [RW+1];
    logic zero_s [RW+1];

    assign vld_s[0]  = vld0_q;
    assign s_s[0]    = sq_q[p];
    assign root_s[0] = '0;
    assign rem_s[0]  = '0;
    assign num_s[0]  = num_q[p];
    assign zero_s[0] = zero_q[p];

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
      atgr_sqrt_cell #(.K(k)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (vld_s[k]),
        .s_i    (s_s[k]),
        .root_i (root_s[k]),
        .rem_i  (rem_s[k]),
        .num_i  (num_s[k]),
        .zero_i (zero_s[k]),
        .vld_o  (vld_s[k+1]),
        .s_o    (s_s[k+1]),
        .root_o (root_s[k+1]),
        .rem_o  (rem_s[k+1]),
        .num_o  (num_s[k+1]),
        .zero_o (zero_s[k+1])
      );
    end

    logic vld_c [CORDIC_STEPS+1];
    logic signed [atgr_pkg::XyW-1:0] x_c [CORDIC_STEPS+1];
    logic signed [atgr_pkg::XyW-1:0] y_c [CORDIC_STEPS+1];
    logic signed [atgr_pkg::ZW-1:0] z_c [CORDIC_STEPS+1];
    logic zero_c [CORDIC_STEPS+1];

    // The hypot carries ten fraction bits; so does the numerator.
    assign vld_c[0]  = vld_s[RW];
    assign x_c[0]    = $signed({{(atgr_pkg::XyW-RW){1'b0}}, root_s[RW]});
    assign y_c[0]    = $signed({{(atgr_pkg::XyW-26){num_s[RW][15]}}, num_s[RW], 10'b0});
    assign z_c[0]    = '0;
    assign zero_c[0] = zero_s[RW];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      atgr_cordic_cell #(.STEP(i)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (vld_c[i]),
        .x_i    (x_c[i]),
        .y_i    (y_c[i]),
        .z_i    (z_c[i]),
        .zero_i (zero_c[i]),
        .vld_o  (vld_c[i+1]),
        .x_o    (x_c[i+1]),
        .y_o    (y_c[i+1]),
        .z_o    (z_c[i+1]),
        .zero_o (zero_c[i+1])
      );
    end

    assign vld_t[p]  = vld_c[CORDIC_STEPS];
    assign z_t[p]    = z_c[CORDIC_STEPS];
    assign zero_t[p] = zero_c[CORDIC_STEPS];
  end

  // Gyro rates, then a delay line to meet the tilt angles.
  logic signed [15:0] rate_r [3];
  logic signed [15:0] rdly_q [3][DLY];

  atgr_rate u_rate_x (.clk_i(clk_i), .rot_i(in_i.rot_x), .bias_i(bias_x_q), .rate_o(rate_r[0]));
  atgr_rate u_rate_y (.clk_i(clk_i), .rot_i(in_i.rot_y), .bias_i(bias_y_q), .rate_o(rate_r[1]));
  atgr_rate u_rate_z (.clk_i(clk_i), .rot_i(in_i.rot_z), .bias_i(bias_z_q), .rate_o(rate_r[2]));

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      rdly_q[a][0] <= rate_r[a];
      for (int j = 1; j < DLY; j++) begin
        rdly_q[a][j] <= rdly_q[a][j-1];
      end
    end
  end

  // Output stage: round the angle to Q1.14 and clamp it.
  logic signed [15:0] tilt_d [2];

  for (genvar p = 0; p < 2; p++) begin : g_round
    logic signed [atgr_pkg::ZW-1:0] zr;
    logic signed [16:0] zs;
    assign zr = z_t[p] + atgr_pkg::ZW'(32768);
    assign zs = zr[32:16];
    always_comb begin
      if (zero_t[p]) begin
        tilt_d[p] = 16'sd0;
      end else if (zs > atgr_pkg::TiltLimit) begin
        tilt_d[p] = atgr_pkg::TiltLimit[15:0];
      end else if (zs < -atgr_pkg::TiltLimit) begin
        tilt_d[p] = 16'(-atgr_pkg::TiltLimit);
      end else begin
        tilt_d[p] = zs[15:0];
      end
    end
  end

  logic done_q;
  atgr_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_t[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.tilt_x <= tilt_d[0];
    res_q.tilt_y <= tilt_d[1];
    res_q.rate_x <= rdly_q[0][DLY-1];
    res_q.rate_y <= rdly_q[1][DLY-1];
    res_q.rate_z <= rdly_q[2][DLY-1];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
